>>> design/ezq_pkg.sv
// ----------------------------------------------------------------------------
// ezq_pkg
// Shared types and constants of the Z-Y-X Euler angle to quaternion block.
// ----------------------------------------------------------------------------
package ezq_pkg;

	localparam int ANGLE_W     = 16;
	localparam int QUAT_W      = 16;
	localparam int CW          = 33;	// Q30 values with sign and headroom
	localparam int ZW          = 34;	// angle accumulator
	localparam int ATAN_N      = 24;
	localparam int STAGES_DEF  = 16;

	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CW-1:0] GAIN_Q30    = 33'sd652032874;
	localparam logic signed [QUAT_W-1:0] ONE_Q14 = 16'sd16384;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] yaw_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] roll_angle;
	} angles_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
	} quat_t;

	// arctangent of 2^-i in Q30 radians
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837830;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = ZW'(64'sd1 <<< (30 - i));
		endcase
		return r;
	endfunction

endpackage

>>> design/ezq_if.sv
// ----------------------------------------------------------------------------
// ezq_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ezq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/ezq_cordic.sv
// ----------------------------------------------------------------------------
// ezq_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of half a Q3.13 angle.
// One register stage per iteration plus one for folding; advances on en.
// ----------------------------------------------------------------------------
module ezq_cordic #(
	parameter int STAGES = ezq_pkg::STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ezq_pkg::ANGLE_W-1:0]  angle,
	output logic signed [ezq_pkg::CW-1:0]       cos_out,
	output logic signed [ezq_pkg::CW-1:0]       sin_out
);
	localparam int N  = (STAGES < ezq_pkg::ATAN_N) ? STAGES : ezq_pkg::ATAN_N;
	localparam int CW = ezq_pkg::CW;
	localparam int ZW = ezq_pkg::ZW;

	logic signed [CW-1:0] x_q [0:N];
	logic signed [CW-1:0] y_q [0:N];
	logic signed [ZW-1:0] z_q [0:N];
	logic                 f_q [0:N];

	logic signed [ZW-1:0] z0;
	assign z0 = ZW'(angle) <<< 16;

	// fold the half angle into [-pi/2, pi/2]
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= ezq_pkg::GAIN_Q30;
			y_q[0] <= '0;
			if (z0 > ezq_pkg::HALF_PI_Q30) begin
				z_q[0] <= z0 - ezq_pkg::PI_Q30;
				f_q[0] <= 1'b1;
			end else if (z0 < -ezq_pkg::HALF_PI_Q30) begin
				z_q[0] <= z0 + ezq_pkg::PI_Q30;
				f_q[0] <= 1'b1;
			end else begin
				z_q[0] <= z0;
				f_q[0] <= 1'b0;
			end
		end
	end

	// micro-rotations
	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				f_q[i+1] <= f_q[i];
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - ezq_pkg::atan_q30(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + ezq_pkg::atan_q30(i);
				end
			end
		end
	end

	assign cos_out = f_q[N] ? -x_q[N] : x_q[N];
	assign sin_out = f_q[N] ? -y_q[N] : y_q[N];
endmodule

>>> design/ezq_combine.sv
// ----------------------------------------------------------------------------
// ezq_combine
// Triple-product sums forming w, x, y, z, rounded and saturated to Q1.14.
// Three register stages: pair products, triple products, sum and round.
// ----------------------------------------------------------------------------
module ezq_combine (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [ezq_pkg::CW-1:0] cy,
	input  logic signed [ezq_pkg::CW-1:0] sy,
	input  logic signed [ezq_pkg::CW-1:0] cp,
	input  logic signed [ezq_pkg::CW-1:0] sp,
	input  logic signed [ezq_pkg::CW-1:0] cr,
	input  logic signed [ezq_pkg::CW-1:0] sr,
	output ezq_pkg::quat_t                quat
);
	localparam int CW = ezq_pkg::CW;
	localparam int PW = 2 * CW;
	localparam int TW = 64;

	// pair products rounded to Q30: cr*cp, sr*sp, sr*cp, cr*sp
	logic signed [CW-1:0] pp_s1 [0:3];
	logic signed [CW-1:0] cy_s1, sy_s1;
	logic signed [PW-1:0] raw [0:3];

	assign raw[0] = cr * cp;
	assign raw[1] = sr * sp;
	assign raw[2] = sr * cp;
	assign raw[3] = cr * sp;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				pp_s1[k] <= CW'((raw[k] + (PW'(1) <<< 29)) >>> 30);
			cy_s1 <= cy;
			sy_s1 <= sy;
		end
	end

	// eight Q60 triple products
	logic signed [TW-1:0] t_s2 [0:7];
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2[0] <= TW'(pp_s1[0] * cy_s1);	// cr cp cy
			t_s2[1] <= TW'(pp_s1[1] * sy_s1);	// sr sp sy
			t_s2[2] <= TW'(pp_s1[2] * cy_s1);	// sr cp cy
			t_s2[3] <= TW'(pp_s1[3] * sy_s1);	// cr sp sy
			t_s2[4] <= TW'(pp_s1[3] * cy_s1);	// cr sp cy
			t_s2[5] <= TW'(pp_s1[2] * sy_s1);	// sr cp sy
			t_s2[6] <= TW'(pp_s1[0] * sy_s1);	// cr cp sy
			t_s2[7] <= TW'(pp_s1[1] * cy_s1);	// sr sp cy
		end
	end

	function automatic logic signed [ezq_pkg::QUAT_W-1:0] to_q14(
		input logic signed [TW-1:0] v);
		logic signed [TW-1:0] r;
		r = (v + (TW'(1) <<< 45)) >>> 46;
		if (r > TW'(ezq_pkg::ONE_Q14))
			return ezq_pkg::ONE_Q14;
		if (r < -TW'(ezq_pkg::ONE_Q14))
			return -ezq_pkg::ONE_Q14;
		return ezq_pkg::QUAT_W'(r);
	endfunction

	// sums, rounding and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_w <= to_q14(t_s2[0] + t_s2[1]);
			quat.quat_x <= to_q14(t_s2[2] - t_s2[3]);
			quat.quat_y <= to_q14(t_s2[4] + t_s2[5]);
			quat.quat_z <= to_q14(t_s2[6] - t_s2[7]);
		end
	end
endmodule

>>> design/euler_zyx_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_quaternion_core
// Z-Y-X Euler angles (Q3.13 rad) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
// channel   dir  payload                              handshake
// in_ch     in   yaw_angle, pitch_angle, roll_angle   valid/ready
// out_ch    out  quat_w, quat_x, quat_y, quat_z       valid/ready
//
// Pipe stages: fold, one per CORDIC iteration, three combine stages; one
// request accepted every cycle unless the output stalls.
// The whole pipe advances as one when the output slot is empty or taken;
// a stall freezes every stage, so nothing is dropped or repeated.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module euler_zyx_to_quaternion_core #(
	parameter int CORDIC_STAGES = ezq_pkg::STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ezq_if.sink   in_ch,
	ezq_if.source out_ch
);
	localparam int N   = (CORDIC_STAGES < ezq_pkg::ATAN_N) ? CORDIC_STAGES : ezq_pkg::ATAN_N;
	localparam int LAT = N + 4;

	ezq_pkg::angles_t a;
	logic [LAT-1:0]   vld_q;
	logic             en;

	assign a  = in_ch.payload;
	assign en = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;

	// valid bits march with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	logic signed [ezq_pkg::CW-1:0] cy, sy, cp, sp, cr, sr;

	ezq_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .angle(a.yaw_angle), .cos_out(cy), .sin_out(sy));
	ezq_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .angle(a.pitch_angle), .cos_out(cp), .sin_out(sp));
	ezq_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .angle(a.roll_angle), .cos_out(cr), .sin_out(sr));

	ezq_pkg::quat_t q;
	ezq_combine u_comb (
		.clk(clk), .en(en), .cy(cy), .sy(sy), .cp(cp), .sp(sp), .cr(cr), .sr(sr),
		.quat(q));

	assign out_ch.valid   = vld_q[LAT-1];
	assign out_ch.payload = q;

	// a stalled result keeps its valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result lost during stall");

	// input is taken whenever the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("pipe blocked with empty output");

	// quat_w stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (q.quat_w <= ezq_pkg::ONE_Q14 && q.quat_w >= -ezq_pkg::ONE_Q14))
		else $error("quat_w out of range");
endmodule
